// ===== sv/paired_actuator_drive_tracker_top_defines.svh =====
// Assertion macros for the paired actuator drive tracker.
`ifndef PAIRED_ACTUATOR_DRIVE_TRACKER_TOP_DEFINES_SVH
`define PAIRED_ACTUATOR_DRIVE_TRACKER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Checked with reset masked.
`define PADT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked at every edge, reset included.
`define PADT_ASSERT_NR(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define PADT_ASSERT(lbl, prop, msg)
`define PADT_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// ===== sv/padt_pkg.sv =====
// Types and constants shared by the paired actuator drive tracker.
package padt_pkg;

   localparam logic [2:0] OP_FWD   = 3'd0;
   localparam logic [2:0] OP_BWD   = 3'd1;
   localparam logic [2:0] OP_OFF   = 3'd2;
   localparam logic [2:0] OP_BRAKE = 3'd3;
   localparam logic [2:0] OP_POLL  = 3'd4;
   localparam logic [2:0] OP_READ  = 3'd5;

   localparam logic [1:0] CODE_OFF   = 2'd0;
   localparam logic [1:0] CODE_FWD   = 2'd1;
   localparam logic [1:0] CODE_BWD   = 2'd2;
   localparam logic [1:0] CODE_BRAKE = 2'd3;

   localparam logic [1:0] POS_CLOSED  = 2'd0;
   localparam logic [1:0] POS_OPEN    = 2'd1;
   localparam logic [1:0] POS_BETWEEN = 2'd2;

   localparam logic [1:0] CSR_PAIR_MAP = 2'd0;
   localparam logic [1:0] CSR_COUNT    = 2'd1;

   localparam logic [20:0] PAIR_MAP_RESET = 21'd1754760;
   localparam logic [2:0]  COUNT_RESET    = 3'd7;

   typedef struct packed {
      logic [2:0] opcode;
      logic [2:0] actuator;
   } req_type;

   typedef struct packed {
      logic [2:0] index;
      logic [1:0] drive_code;
      logic [1:0] position;
      logic       last;
   } rsp_type;

   // One memory word per actuator.
   typedef struct packed {
      logic [1:0] drive;
      logic [1:0] polled;
      logic [1:0] position;
   } entry_type;

endpackage

// ===== sv/paired_actuator_drive_tracker_top.sv =====
// Paired actuator drive tracker: command decode, state memory and result walk.
//
// The req channel takes one item per command: opcode and actuator index.
// Drive commands (forward, backward, off, brake) update the named actuator
// and its partner from the pair map; they give no result and are done as
// a read-modify-write of the state memory: the entry is read on acceptance
// and written in ST_DMOD; a valid partner is read there, written in ST_PMOD.
// Polls and position reads give one rsp item per actuator in use, index 0
// first, with last set on the final one. Each result passes the registered
// memory read and the rsp register, and the walk produces one result per
// cycle while rsp_ready is high. The rsp register lets a new item be
// accepted while the final result still waits.
// When the receiver stalls, the walk holds on the current entry and the
// memory read data stays put until the result register frees up.
// Reset clears the valid bit of every memory entry, so all drive codes
// and positions read as off and closed; the pair map and actuator count
// return to their defaults. The csr port writes the pair map (index 0)
// or the actuator count (index 1) and should only be used while idle.
`include "paired_actuator_drive_tracker_top_defines.svh"
module paired_actuator_drive_tracker_top
   import padt_pkg::*;
#(
   parameter int unsigned MAX_ACTUATORS = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [20:0] csr_wdata
);

   localparam int unsigned AW  = (MAX_ACTUATORS > 1) ? $clog2(MAX_ACTUATORS) : 1;
   localparam int unsigned CAP = (MAX_ACTUATORS < 7) ? MAX_ACTUATORS : 7;
   localparam logic [2:0]  CAP3 = 3'(CAP);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DMOD,
      ST_PMOD,
      ST_SCAN
   } state_type;

   state_type        state_ff, state_in;
   logic [20:0]      pair_map_ff;
   logic [2:0]       count_ff;
   logic [2:0]       act_ff, act_in;
   logic [1:0]       code_ff, code_in;
   logic             poll_ff, poll_in;
   logic [2:0]       idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   entry_type        mem [MAX_ACTUATORS];
   logic [MAX_ACTUATORS-1:0] valid_ff;
   entry_type        rd_data_ff;
   logic             rd_valid_ff;
   logic             rd_en, mem_we;
   logic [AW-1:0]    rd_addr, wr_addr;
   entry_type        wr_data;

   logic [2:0]       n_use;
   logic [2:0]       partner;
   logic             partner_ok;
   logic             slot_free;
   entry_type        ent, ent_drive, ent_poll;

   // Count of zero acts as one; the count is capped at the memory depth.
   always_comb begin
      if (count_ff == 3'd0) begin
         n_use = 3'd1;
      end else if (count_ff > CAP3) begin
         n_use = CAP3;
      end else begin
         n_use = count_ff;
      end
   end

   assign partner    = pair_map_ff[3*act_ff +: 3];
   assign partner_ok = (partner < n_use) && (partner != act_ff);
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign ent        = rd_valid_ff ? rd_data_ff : '0;

   // Drive update keeps the polled code of the entry.
   always_comb begin
      ent_drive       = ent;
      ent_drive.drive = code_ff;
      if ((code_ff == CODE_FWD) || (code_ff == CODE_BWD)) begin
         ent_drive.position = POS_BETWEEN;
      end
   end

   // A code that went to off since the last poll settles the position.
   always_comb begin
      ent_poll        = ent;
      ent_poll.polled = ent.drive;
      if (ent.drive == CODE_OFF) begin
         if (ent.polled == CODE_FWD) begin
            ent_poll.position = POS_OPEN;
         end else if (ent.polled == CODE_BWD) begin
            ent_poll.position = POS_CLOSED;
         end
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      code_in      = code_ff;
      poll_in      = poll_ff;
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_en        = 1'b0;
      rd_addr      = '0;
      mem_we       = 1'b0;
      wr_addr      = '0;
      wr_data      = ent_drive;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               act_in  = req_data.actuator;
               poll_in = (req_data.opcode == OP_POLL);
               idx_in  = 3'd0;
               unique case (req_data.opcode)
                  OP_FWD:   code_in = CODE_FWD;
                  OP_BWD:   code_in = CODE_BWD;
                  OP_OFF:   code_in = CODE_OFF;
                  default:  code_in = CODE_BRAKE;
               endcase
               if ((req_data.opcode <= OP_BRAKE) && (req_data.actuator < n_use)) begin
                  rd_en    = 1'b1;
                  rd_addr  = AW'(req_data.actuator);
                  state_in = ST_DMOD;
               end else if ((req_data.opcode == OP_POLL) || (req_data.opcode == OP_READ)) begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_DMOD: begin
            mem_we  = 1'b1;
            wr_addr = AW'(act_ff);
            if (partner_ok) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(partner);
               state_in = ST_PMOD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PMOD: begin
            mem_we   = 1'b1;
            wr_addr  = AW'(partner);
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (slot_free) begin
               mem_we       = poll_ff;
               wr_addr      = AW'(idx_ff);
               wr_data      = ent_poll;
               rsp_valid_in = 1'b1;
               rsp_in.index = idx_ff;
               rsp_in.last  = (idx_ff == n_use - 3'd1);
               if (poll_ff) begin
                  rsp_in.drive_code = ent_poll.drive;
                  rsp_in.position   = ent_poll.position;
               end else begin
                  rsp_in.drive_code = ent.drive;
                  rsp_in.position   = ent.position;
               end
               if (idx_ff == n_use - 3'd1) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 3'd1;
                  rd_en    = 1'b1;
                  rd_addr  = AW'(idx_ff + 3'd1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff  <= act_in;
      code_ff <= code_in;
      poll_ff <= poll_in;
      idx_ff  <= idx_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_map_ff <= PAIR_MAP_RESET;
         count_ff    <= COUNT_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_PAIR_MAP) begin
            pair_map_ff <= csr_wdata;
         end else if (csr_index == CSR_COUNT) begin
            count_ff <= csr_wdata[2:0];
         end
      end
   end

   // State memory: one write and one read port, registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // An entry never written since reset reads as off and closed.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `PADT_ASSERT(a_no_same_entry, (mem_we && rd_en) |-> (wr_addr != rd_addr), "read and write hit one entry")
   `PADT_ASSERT(a_last_index, (rsp_valid_ff && rsp_ff.last) |-> (rsp_ff.index == n_use - 3'd1), "last flag on wrong index")
   `PADT_ASSERT(a_rsp_from_scan, $rose(rsp_valid_ff) |-> $past(state_ff == ST_SCAN), "result loaded outside walk")
   `PADT_ASSERT_NR(a_reset_clears, $past(reset) |-> (valid_ff == '0), "valid bits not cleared by reset")

endmodule

// ===== test/padt_drive_checker.sv =====
// Checker for the paired actuator drive tracker: tracks drive state and compares every result.
`timescale 1ns / 100ps
module padt_drive_checker
   import padt_pkg::*;
#(
   parameter int unsigned MAX_ACTUATORS = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [20:0] csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          results_seen
);

   logic [20:0] partner_map;
   logic [2:0]  count_reg;
   logic [1:0]  drive_now [MAX_ACTUATORS];
   logic [1:0]  drive_at_poll [MAX_ACTUATORS];
   logic [1:0]  believed_pos [MAX_ACTUATORS];
   rsp_type     report_q [$];

   function automatic int actuators_in_use();
      int n;
      n = int'(count_reg);
      if (n == 0) n = 1;
      if (n > MAX_ACTUATORS) n = MAX_ACTUATORS;
      return n;
   endfunction

   task automatic set_drive(input int act, input logic [1:0] code);
      drive_now[act] = code;
      if (code == CODE_FWD || code == CODE_BWD) believed_pos[act] = POS_BETWEEN;
   endtask

   task automatic queue_report(input int idx, input int n);
      rsp_type r;
      r.index      = idx[2:0];
      r.drive_code = drive_now[idx];
      r.position   = believed_pos[idx];
      r.last       = (idx == n - 1);
      report_q.push_back(r);
   endtask

   task automatic apply_command(input req_type cmd);
      int n;
      int act;
      int partner;
      logic [1:0] code;
      n = actuators_in_use();
      act = int'(cmd.actuator);
      case (cmd.opcode)
         OP_FWD, OP_BWD, OP_OFF, OP_BRAKE: begin
            if (act < n) begin
               case (cmd.opcode)
                  OP_FWD:  code = CODE_FWD;
                  OP_BWD:  code = CODE_BWD;
                  OP_OFF:  code = CODE_OFF;
                  default: code = CODE_BRAKE;
               endcase
               set_drive(act, code);
               partner = int'(partner_map[3 * act +: 3]);
               // A partner beyond the count, or the actuator itself, is not driven again.
               if (partner < n && partner != act) set_drive(partner, code);
            end
         end
         OP_POLL: begin
            for (int i = 0; i < n; i++) begin
               // An actuator that has stopped since the last poll settles at an end stop.
               if (drive_now[i] == CODE_OFF) begin
                  if (drive_at_poll[i] == CODE_FWD) believed_pos[i] = POS_OPEN;
                  else if (drive_at_poll[i] == CODE_BWD) believed_pos[i] = POS_CLOSED;
               end
               drive_at_poll[i] = drive_now[i];
               queue_report(i, n);
            end
         end
         OP_READ: begin
            for (int i = 0; i < n; i++) queue_report(i, n);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         partner_map = PAIR_MAP_RESET;
         count_reg = COUNT_RESET;
         for (int i = 0; i < MAX_ACTUATORS; i++) begin
            drive_now[i] = CODE_OFF;
            drive_at_poll[i] = CODE_OFF;
            believed_pos[i] = POS_CLOSED;
         end
         report_q.delete();
         fail_count = 0;
         results_seen = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (report_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result index %0d drive %0d pos %0d last %0b",
                           $time, rsp_data.index, rsp_data.drive_code, rsp_data.position,
                           rsp_data.last);
            end else begin
               want = report_q.pop_front();
               if (rsp_data.index !== want.index || rsp_data.drive_code !== want.drive_code ||
                   rsp_data.position !== want.position || rsp_data.last !== want.last) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: result mismatch, expected index %0d drive %0d pos %0d last %0b",
                              $time, want.index, want.drive_code, want.position, want.last);
                     $display("%0t:                  actual index %0d drive %0d pos %0d last %0b",
                              $time, rsp_data.index, rsp_data.drive_code, rsp_data.position,
                              rsp_data.last);
                  end
               end
            end
         end
         if (req_valid && req_ready) apply_command(req_data);
         if (csr_we) begin
            if (csr_index == CSR_PAIR_MAP) partner_map = csr_wdata;
            else if (csr_index == CSR_COUNT) count_reg = csr_wdata[2:0];
         end
      end
      pending = report_q.size();
   end

endmodule

// ===== test/paired_actuator_drive_tracker_top_test.sv =====
// Testbench top for the paired actuator drive tracker: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module paired_actuator_drive_tracker_top_test;
   import padt_pkg::*;

   localparam int unsigned MAX_ACTUATORS = 7;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 12;

   // Opcodes and register indexes that the block decodes as nothing.
   localparam logic [2:0] OP_SPARE_LO  = 3'd6;
   localparam logic [2:0] OP_SPARE_HI  = 3'd7;
   localparam logic [1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [1:0] CSR_SPARE_HI = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [20:0] csr_wdata;

   int fail_count;
   int pending;
   int results_seen;
   int send_idle_pct;
   int stall_pct;
   int cfg_count;
   int commands_sent;
   int settings_used;

   paired_actuator_drive_tracker_top #(.MAX_ACTUATORS(MAX_ACTUATORS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   padt_drive_checker #(.MAX_ACTUATORS(MAX_ACTUATORS)) tracker_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .pending(pending),
      .results_seen(results_seen)
   );

   always #4 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= stall_pct);
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("Timeout: no item moved for %0d cycles.", QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // All tasks below start and end at a falling edge.
   task automatic write_reg(input logic [1:0] idx, input logic [20:0] data);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      if (idx == CSR_COUNT) cfg_count = int'(data[2:0]);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Wait until every result is back and any drive command has finished its update.
   task automatic drain();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic send_cmd(input logic [2:0] op, input logic [2:0] act);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data.opcode = op;
      req_data.actuator = act;
      do @(posedge clock); while (!req_ready);
      commands_sent++;
      @(negedge clock);
   endtask

   // Count in the low bits; the upper bits are junk that the block must ignore.
   function automatic logic [20:0] count_word(input int n);
      logic [20:0] w;
      w = 21'($urandom);
      w[2:0] = 3'(n);
      return w;
   endfunction

   function automatic logic [20:0] random_pair_map(input int n);
      logic [20:0] m;
      for (int i = 0; i < 7; i++)
         m[3 * i +: 3] = 3'(($urandom_range(99) < 80) ? $urandom_range(n - 1)
                                                       : $urandom_range(7));
      return m;
   endfunction

   task automatic run_phase(input int items, input int idle_pct, input int stall);
      logic [2:0] op;
      logic [2:0] act;
      int n;
      int pick;
      send_idle_pct = idle_pct;
      stall_pct = stall;
      settings_used++;
      n = (cfg_count == 0) ? 1 : cfg_count;
      repeat (items) begin
         if ($urandom_range(99) < 4 && pending != 0) begin
            req_valid = 1'b0;
            while (pending != 0) @(negedge clock);
         end
         pick = $urandom_range(99);
         if (pick < 62) op = 3'($urandom_range(OP_FWD, OP_BRAKE));
         else if (pick < 80) op = OP_POLL;
         else if (pick < 92) op = OP_READ;
         else op = 3'($urandom_range(0, 7));
         act = 3'(($urandom_range(99) < 85) ? $urandom_range(n - 1) : $urandom_range(7));
         send_cmd(op, act);
      end
   endtask

   initial begin : stimulus
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_PAIR_MAP;
      csr_wdata = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      cfg_count = int'(COUNT_RESET);
      commands_sent = 0;
      settings_used = 1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Pairs 0 and 1, 2 and 3; 4 drives 5 but not back; 6 is its own partner.
      write_reg(CSR_COUNT, count_word(7));
      write_reg(CSR_PAIR_MAP, {3'd6, 3'd7, 3'd5, 3'd2, 3'd3, 3'd0, 3'd1});
      send_cmd(OP_POLL, 3'd0);
      send_cmd(OP_READ, 3'd7);
      send_cmd(OP_FWD, 3'd0);
      send_cmd(OP_BWD, 3'd2);
      send_cmd(OP_BRAKE, 3'd4);
      send_cmd(OP_FWD, 3'd6);
      send_cmd(OP_READ, 3'd0);
      send_cmd(OP_POLL, 3'd5);
      send_cmd(OP_OFF, 3'd1);
      send_cmd(OP_OFF, 3'd3);
      send_cmd(OP_OFF, 3'd4);
      send_cmd(OP_OFF, 3'd6);
      // Stopped after forward ends open, after backward closed, after brake unchanged.
      send_cmd(OP_POLL, 3'd0);
      send_cmd(OP_FWD, 3'd7);
      send_cmd(OP_SPARE_LO, 3'd0);
      send_cmd(OP_SPARE_HI, 3'd7);
      send_cmd(OP_BWD, 3'd5);
      send_cmd(OP_POLL, 3'd0);
      send_cmd(OP_BRAKE, 3'd5);
      send_cmd(OP_POLL, 3'd0);
      send_cmd(OP_OFF, 3'd4);
      send_cmd(OP_POLL, 3'd0);
      send_cmd(OP_READ, 3'd0);
      drain();

      write_reg(CSR_COUNT, count_word(7));
      write_reg(CSR_PAIR_MAP, PAIR_MAP_RESET);
      run_phase(50, 0, 0);
      drain();

      write_reg(CSR_COUNT, count_word(4));
      write_reg(CSR_PAIR_MAP, random_pair_map(4));
      run_phase(50, 45, 0);
      drain();

      write_reg(CSR_COUNT, count_word(0));
      write_reg(CSR_PAIR_MAP, '0);
      run_phase(40, 0, 45);
      drain();

      write_reg(CSR_COUNT, count_word(7));
      write_reg(CSR_PAIR_MAP, '1);
      run_phase(50, 27, 27);
      drain();

      write_reg(CSR_COUNT, count_word(1));
      write_reg(CSR_PAIR_MAP, random_pair_map(1));
      write_reg(CSR_SPARE_LO, 21'($urandom));
      write_reg(CSR_SPARE_HI, 21'($urandom));
      run_phase(30, 0, 0);
      drain();

      write_reg(CSR_COUNT, count_word(3));
      write_reg(CSR_PAIR_MAP, random_pair_map(3));
      run_phase(70, 27, 27);
      drain();

      $display("Sent %0d commands under %0d register settings; %0d results compared.",
               commands_sent, settings_used, results_seen);
      $display("Counts from 1 to 7, self, paired and out-of-range partners, spare opcodes.");
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== paired_actuator_drive_tracker_top.f =====
+incdir+sv
sv/padt_pkg.sv
sv/paired_actuator_drive_tracker_top.sv
test/padt_drive_checker.sv
test/paired_actuator_drive_tracker_top_test.sv
